// File: rtl/tgarle_pkg.sv
// Shared types and constants for the TGA run-length pixel decoder.
`default_nettype none

package tgarle_pkg;

  localparam int unsigned QueueDepth = 2;

  localparam logic [7:0] RunFlag   = 8'h80;
  localparam logic [7:0] CountMask = 8'h7F;

  typedef enum logic [1:0] {
    REG_RLE_MODE        = 2'd0,
    REG_BYTES_PER_PIXEL = 2'd1,
    REG_IMAGE_WIDTH     = 2'd2,
    REG_IMAGE_HEIGHT    = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    PIX_1B = 2'd0,
    PIX_2B = 2'd1,
    PIX_3B = 2'd2,
    PIX_4B = 2'd3
  } pix_size_e;

  typedef struct packed {
    logic [31:0] px;
    logic [7:0]  rep;
    logic        last;
    logic        ov;
    pix_size_e   size;
  } pix_item_t;

endpackage

`default_nettype wire

// File: rtl/tgarle_front.sv
// Front end: configuration registers, packet parsing and pixel byte gathering.
`default_nettype none

module tgarle_front (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      cfg_we_i,
  input  wire  [1:0]               cfg_idx_i,
  input  wire  [15:0]              cfg_wdata_i,
  input  wire                      accept_i,
  input  wire  [7:0]               data_byte_i,
  output logic                     emit_o,
  output tgarle_pkg::pix_item_t    item_o
);
  import tgarle_pkg::*;

  logic        rle_q, rle_d;
  logic [2:0]  bpp_q, bpp_d;
  logic [15:0] width_q, width_d;
  logic [15:0] height_q, height_d;
  logic        hdr_q, hdr_d;
  logic        run_q, run_d;
  logic        pov_q, pov_d;
  logic [7:0]  left_q, left_d;
  logic [1:0]  pos_q, pos_d;
  logic [23:0] gather_q, gather_d;
  logic [31:0] rem_q, rem_d;

  pix_size_e   size;
  logic [7:0]  count;
  logic [7:0]  rep;
  logic [31:0] px;
  logic [31:0] rem_next;
  logic [31:0] area;

  always_comb begin
    if (bpp_q == 3'd0) begin
      size = PIX_1B;
    end else if (bpp_q > 3'd4) begin
      size = PIX_4B;
    end else begin
      size = pix_size_e'(2'(bpp_q - 3'd1));
    end
  end

  always_comb begin
    rle_d    = rle_q;
    bpp_d    = bpp_q;
    width_d  = width_q;
    height_d = height_q;
    if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_RLE_MODE:        rle_d    = cfg_wdata_i[0];
        REG_BYTES_PER_PIXEL: bpp_d    = cfg_wdata_i[2:0];
        REG_IMAGE_WIDTH:     width_d  = cfg_wdata_i;
        REG_IMAGE_HEIGHT:    height_d = cfg_wdata_i;
        default:             rle_d    = rle_q;
      endcase
    end
    area = {16'd0, width_d} * {16'd0, height_d};
  end

  always_comb begin
    hdr_d    = hdr_q;
    run_d    = run_q;
    pov_d    = pov_q;
    left_d   = left_q;
    pos_d    = pos_q;
    gather_d = gather_q;
    rem_d    = rem_q;
    emit_o   = 1'b0;
    count    = (data_byte_i & CountMask) + 8'd1;
    rep      = 8'd1;
    px       = {8'd0, gather_q};
    rem_next = rem_q;

    case (pos_q)
      2'd0:    px = px | {24'd0, data_byte_i};
      2'd1:    px = px | {16'd0, data_byte_i, 8'd0};
      2'd2:    px = px | {8'd0, data_byte_i, 16'd0};
      default: px = px | {data_byte_i, 24'd0};
    endcase

    if (run_q && rle_q) begin
      rep = left_q;
    end
    if (rep == 8'd0) begin
      rep = 8'd1;
    end
    if ({24'd0, rep} > rem_q) begin
      rep = rem_q[7:0];
    end
    rem_next = rem_q - {24'd0, rep};

    if (cfg_we_i) begin
      rem_d    = area;
      hdr_d    = rle_d;
      run_d    = 1'b0;
      pov_d    = 1'b0;
      left_d   = 8'd0;
      pos_d    = 2'd0;
      gather_d = 24'd0;
    end else if (accept_i && rem_q != 32'd0) begin
      if (rle_q && hdr_q) begin
        pov_d = 1'b0;
        if ({24'd0, count} > rem_q) begin
          count = rem_q[7:0];
          pov_d = 1'b1;
        end
        run_d    = (data_byte_i & RunFlag) != 8'd0;
        left_d   = count;
        hdr_d    = 1'b0;
        pos_d    = 2'd0;
        gather_d = 24'd0;
      end else if (pos_q != size) begin
        gather_d = px[23:0];
        pos_d    = pos_q + 2'd1;
      end else begin
        emit_o   = 1'b1;
        gather_d = 24'd0;
        pos_d    = 2'd0;
        rem_d    = rem_next;
        if (rle_q) begin
          if (run_q) begin
            left_d = 8'd0;
            hdr_d  = 1'b1;
          end else begin
            if (left_q != 8'd0) begin
              left_d = left_q - 8'd1;
            end
            if (left_d == 8'd0) begin
              hdr_d = 1'b1;
            end
          end
        end
      end
    end
  end

  always_comb begin
    item_o.px   = px;
    item_o.rep  = rep;
    item_o.last = rem_next == 32'd0;
    item_o.ov   = rle_q & pov_q;
    item_o.size = size;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rle_q    <= 1'b0;
      bpp_q    <= 3'd4;
      width_q  <= 16'd1;
      height_q <= 16'd1;
      hdr_q    <= 1'b0;
      run_q    <= 1'b0;
      pov_q    <= 1'b0;
      left_q   <= 8'd0;
      pos_q    <= 2'd0;
      gather_q <= 24'd0;
      rem_q    <= 32'd1;
    end else begin
      rle_q    <= rle_d;
      bpp_q    <= bpp_d;
      width_q  <= width_d;
      height_q <= height_d;
      hdr_q    <= hdr_d;
      run_q    <= run_d;
      pov_q    <= pov_d;
      left_q   <= left_d;
      pos_q    <= pos_d;
      gather_q <= gather_d;
      rem_q    <= rem_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/tgarle_queue.sv
// Short queue of gathered pixels between the front end and the back end.
`default_nettype none

module tgarle_queue #(
  parameter int unsigned Depth = tgarle_pkg::QueueDepth
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      wr_i,
  input  wire tgarle_pkg::pix_item_t wr_item_i,
  input  wire                      rd_i,
  output tgarle_pkg::pix_item_t    rd_item_o,
  output logic                     full_o,
  output logic                     empty_o
);
  import tgarle_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  pix_item_t           mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     cnt_q;
  logic                do_wr, do_rd;

  assign full_o    = cnt_q == CntW'(Depth);
  assign empty_o   = cnt_q == '0;
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_item_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/tgarle_back.sv
// Back end: byte swizzle, alpha halving and the result register.
`default_nettype none

module tgarle_back (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      q_empty_i,
  input  wire tgarle_pkg::pix_item_t q_item_i,
  output logic                     q_rd_o,
  input  wire                      pop,
  output logic                     empty,
  output logic [31:0]              pixel_value_o,
  output logic [7:0]               repeat_count_o,
  output logic                     last_o,
  output logic                     overrun_o
);
  import tgarle_pkg::*;

  logic        valid_q;
  logic [31:0] pix_q, pix_d;
  logic [7:0]  rep_q;
  logic        last_q, ov_q;
  logic [7:0]  b0, b1, b2, b3;

  assign b0 = q_item_i.px[7:0];
  assign b1 = q_item_i.px[15:8];
  assign b2 = q_item_i.px[23:16];
  assign b3 = q_item_i.px[31:24];

  always_comb begin
    unique case (q_item_i.size)
      PIX_1B:  pix_d = {24'd0, b0};
      PIX_2B:  pix_d = {16'd0, b0, b1};
      PIX_3B:  pix_d = {8'd0, b0, b1, b2};
      PIX_4B:  pix_d = {1'b0, b3[7:1], b0, b1, b2};
      default: pix_d = {24'd0, b0};
    endcase
  end

  assign q_rd_o = !q_empty_i && (!valid_q || pop);

  always_ff @(posedge clk_i) begin
    if (q_rd_o) begin
      pix_q  <= pix_d;
      rep_q  <= q_item_i.rep;
      last_q <= q_item_i.last;
      ov_q   <= q_item_i.ov;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (q_rd_o) begin
      valid_q <= 1'b1;
    end else if (pop) begin
      valid_q <= 1'b0;
    end
  end

  assign empty          = !valid_q;
  assign pixel_value_o  = pix_q;
  assign repeat_count_o = rep_q;
  assign last_o         = last_q;
  assign overrun_o      = ov_q;

endmodule

`default_nettype wire

// File: rtl/tga_rle_pixel_decoder_unit.sv
// Top level of the TGA run-length pixel decoder.
//
//   Channel  | Handshake             | Payload
//   ---------+-----------------------+-----------------------------------------------
//   input    | push / full           | data_byte_i
//   result   | empty / pop           | pixel_value_o, repeat_count_o, last_o, overrun_o
//   config   | cfg_we_i              | cfg_idx_i, cfg_wdata_i
//
// One byte per cycle is taken unless full; pixels pass the queue and result register.
// The front end computes width times height in the same cycle as a configuration write.
// Reset sets bytes per pixel to four and a one by one raw image.
// When the result is not popped, the queue fills and full rises after two more pixels.
`default_nettype none

module tga_rle_pixel_decoder_unit #(
  parameter int unsigned QueueDepth = tgarle_pkg::QueueDepth
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          cfg_we_i,
  input  wire  [1:0]   cfg_idx_i,
  input  wire  [15:0]  cfg_wdata_i,
  input  wire          push,
  output logic         full,
  input  wire  [7:0]   data_byte_i,
  output logic         empty,
  input  wire          pop,
  output logic [31:0]  pixel_value_o,
  output logic [7:0]   repeat_count_o,
  output logic         last_o,
  output logic         overrun_o
);
  import tgarle_pkg::*;

  logic      emit;
  pix_item_t f_item;
  pix_item_t q_item;
  logic      q_rd;
  logic      q_empty;

  tgarle_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (push && !full),
    .data_byte_i (data_byte_i),
    .emit_o      (emit),
    .item_o      (f_item)
  );

  tgarle_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (emit),
    .wr_item_i (f_item),
    .rd_i      (q_rd),
    .rd_item_o (q_item),
    .full_o    (full),
    .empty_o   (q_empty)
  );

  tgarle_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .q_item_i       (q_item),
    .q_rd_o         (q_rd),
    .pop            (pop),
    .empty          (empty),
    .pixel_value_o  (pixel_value_o),
    .repeat_count_o (repeat_count_o),
    .last_o         (last_o),
    .overrun_o      (overrun_o)
  );

endmodule

`default_nettype wire

// File: sim/tga_rle_pixel_decoder_unit_tb.sv
// Self-checking testbench for the TGA run-length pixel decoder with a predicting scoreboard.
module tga_rle_pixel_decoder_unit_tb;
  import tgarle_pkg::*;

  localparam int unsigned DrainCycles = 8;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned RandomBytes = 1450;

  typedef struct packed {
    logic [31:0] pixel;
    logic [7:0]  count;
    logic        is_last;
    logic        overrun;
  } pixel_result_t;

  class tga_pixel_predictor;
    logic          rle;
    logic [2:0]    bpp;
    logic [15:0]   width;
    logic [15:0]   height;
    logic          expect_header;
    logic          is_run;
    logic          pkt_overrun;
    logic [7:0]    pkt_left;
    logic [1:0]    byte_pos;
    logic [23:0]   gather;
    logic [31:0]   remaining;
    pixel_result_t expected_pixels[$];
    int unsigned   mismatches;

    function new();
      rle = 1'b0;
      bpp = 3'd4;
      width = 16'd1;
      height = 16'd1;
      mismatches = 0;
      rearm();
    endfunction

    function void rearm();
      remaining = 32'(width) * 32'(height);
      expect_header = rle;
      is_run = 1'b0;
      pkt_overrun = 1'b0;
      pkt_left = 8'd0;
      byte_pos = 2'd0;
      gather = 24'd0;
    endfunction

    function void write_reg(reg_idx_e idx, logic [15:0] value);
      case (idx)
        REG_RLE_MODE: begin
          rle = value[0];
        end
        REG_BYTES_PER_PIXEL: begin
          bpp = value[2:0];
        end
        REG_IMAGE_WIDTH: begin
          width = value;
        end
        REG_IMAGE_HEIGHT: begin
          height = value;
        end
        default: begin
        end
      endcase
      rearm();
    endfunction

    function logic [31:0] swizzle(logic [31:0] p, int unsigned n);
      case (n)
        2: begin
          return {16'h0000, p[7:0], p[15:8]};
        end
        3: begin
          return {8'h00, p[7:0], p[15:8], p[23:16]};
        end
        4: begin
          return {1'b0, p[31:25], p[7:0], p[15:8], p[23:16]};
        end
        default: begin
          return {24'h000000, p[7:0]};
        end
      endcase
    endfunction

    function void accept_byte(logic [7:0] b);
      int unsigned   n;
      int unsigned   cnt;
      int unsigned   rep;
      logic [31:0]   px;
      pixel_result_t r;
      n = (bpp == 3'd0) ? 1 : ((bpp > 3'd4) ? 4 : int'(bpp));
      if (remaining == 32'd0) return;
      if (rle && expect_header) begin
        cnt = int'(b & CountMask) + 1;
        pkt_overrun = (cnt > remaining);
        if (pkt_overrun) cnt = remaining;
        is_run = (b & RunFlag) != 8'd0;
        pkt_left = 8'(cnt);
        expect_header = 1'b0;
        byte_pos = 2'd0;
        gather = 24'd0;
        return;
      end
      if (int'(byte_pos) + 1 < n) begin
        gather = gather | 24'(32'(b) << (8 * byte_pos));
        byte_pos++;
        return;
      end
      px = swizzle({8'h00, gather} | (32'(b) << (8 * byte_pos)), n);
      gather = 24'd0;
      byte_pos = 2'd0;
      rep = 1;
      if (rle && is_run) begin
        rep = pkt_left;
        pkt_left = 8'd0;
        expect_header = 1'b1;
      end else if (rle) begin
        if (pkt_left != 8'd0) pkt_left--;
        if (pkt_left == 8'd0) expect_header = 1'b1;
      end
      if (rep == 0) rep = 1;
      if (rep > remaining) rep = remaining;
      remaining -= rep;
      r.pixel = px;
      r.count = 8'(rep);
      r.is_last = (remaining == 32'd0);
      r.overrun = rle && pkt_overrun;
      expected_pixels.push_back(r);
    endfunction

    function void check_pixel(logic [31:0] px, logic [7:0] cnt, logic lst, logic ovr);
      pixel_result_t e;
      if (expected_pixels.size() == 0) begin
        $error("unexpected result: pixel_value %h repeat_count %0d", px, cnt);
        mismatches++;
        return;
      end
      e = expected_pixels.pop_front();
      if (px !== e.pixel) begin
        $error("pixel_value: expected %h, actual %h", e.pixel, px);
        mismatches++;
      end
      if (cnt !== e.count) begin
        $error("repeat_count: expected %0d, actual %0d", e.count, cnt);
        mismatches++;
      end
      if (lst !== e.is_last) begin
        $error("last: expected %b, actual %b", e.is_last, lst);
        mismatches++;
      end
      if (ovr !== e.overrun) begin
        $error("overrun: expected %b, actual %b", e.overrun, ovr);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [15:0] cfg_wdata_i;
  logic        push;
  logic        full;
  logic [7:0]  data_byte_i;
  logic        empty;
  logic        pop;
  logic [31:0] pixel_value_o;
  logic [7:0]  repeat_count_o;
  logic        last_o;
  logic        overrun_o;

  tga_pixel_predictor pixel_pred;
  logic [7:0]         stream_q[$];
  int unsigned        stim_bytes;
  int unsigned        rx_hold;
  int unsigned        cycle_count;
  bit                 tx_idle;
  bit                 rx_idle;

  tga_rle_pixel_decoder_unit u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .push           (push),
    .full           (full),
    .data_byte_i    (data_byte_i),
    .empty          (empty),
    .pop            (pop),
    .pixel_value_o  (pixel_value_o),
    .repeat_count_o (repeat_count_o),
    .last_o         (last_o),
    .overrun_o      (overrun_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  task automatic send_byte(logic [7:0] b);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push <= 1'b1;
    data_byte_i <= b;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    pixel_pred.accept_byte(b);
    @(negedge clk_i);
  endtask

  task automatic send_stream();
    foreach (stream_q[i]) send_byte(stream_q[i]);
    stream_q.delete();
  endtask

  function automatic logic [7:0] pick_header();
    int unsigned sel;
    int unsigned cap;
    int unsigned cnt;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 8'($urandom);
    cap = (pixel_pred.remaining > 8) ? 8 : pixel_pred.remaining;
    cnt = (sel == 1) ? $urandom_range(1, 128) : $urandom_range(1, cap);
    return {1'($urandom), 7'(cnt - 1)};
  endfunction

  task automatic stream_image(int unsigned budget);
    int unsigned sent;
    logic [7:0]  b;
    sent = 0;
    while (pixel_pred.remaining != 32'd0 && sent < budget) begin
      if (pixel_pred.rle && pixel_pred.expect_header) b = pick_header();
      else b = 8'($urandom);
      send_byte(b);
      sent++;
      stim_bytes++;
    end
  endtask

  task automatic configure(logic rle, logic [2:0] bpp, logic [15:0] w, logic [15:0] h);
    logic [15:0] vals[4];
    reg_idx_e    idx;
    vals[0] = {15'($urandom), rle};
    vals[1] = {13'($urandom), bpp};
    vals[2] = w;
    vals[3] = h;
    for (int i = 0; i < 4; i++) begin
      idx = reg_idx_e'(i);
      cfg_we_i <= 1'b1;
      cfg_idx_i <= idx;
      cfg_wdata_i <= vals[i];
      @(negedge clk_i);
      pixel_pred.write_reg(idx, vals[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    push <= 1'b0;
    while (pixel_pred.expected_pixels.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  initial begin
    int unsigned stall;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      stall = (rx_hold > 0) ? rx_hold : (rx_idle ? $urandom_range(0, 8) : 0);
      rx_hold = 0;
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      pop <= 1'b1;
      @(posedge clk_i);
      while (empty) @(posedge clk_i);
      pixel_pred.check_pixel(pixel_value_o, repeat_count_o, last_o, overrun_o);
      @(negedge clk_i);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count <= CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tga_rle_pixel_decoder_unit_tb: FAIL");
    $finish;
  end

  initial begin
    logic        rle;
    logic [2:0]  bpp;
    logic [15:0] w;
    logic [15:0] h;
    int unsigned sel;
    int unsigned budget;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_RLE_MODE;
    cfg_wdata_i = 16'd0;
    push = 1'b0;
    pop = 1'b0;
    data_byte_i = 8'd0;
    stim_bytes = 0;
    rx_hold = 0;
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    pixel_pred = new();
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part: reset image, runs, clamped packets, odd pixel sizes and extreme sizes.
    stream_q = '{8'hFF, 8'h00, 8'h7F, 8'h80, 8'h3C};
    send_stream();
    drain();
    configure(1'b1, 3'd2, 16'd2, 16'd2);
    stream_q = '{8'h81, 8'h12, 8'h34, 8'h05, 8'h56, 8'h78, 8'h9A, 8'hBC};
    send_stream();
    drain();
    configure(1'b1, 3'd3, 16'd1, 16'd1);
    stream_q = '{8'hFF, 8'h01, 8'h02, 8'h03};
    send_stream();
    drain();
    configure(1'b0, 3'd0, 16'd3, 16'd1);
    stream_q = '{8'hAA, 8'h55, 8'h00};
    send_stream();
    drain();
    configure(1'b1, 3'd7, 16'hFFFF, 16'hFFFF);
    stream_q = '{8'h7F, 8'h11, 8'h22, 8'h33, 8'h44};
    send_stream();
    drain();
    configure(1'b0, 3'd1, 16'd0, 16'hFFFF);
    stream_q = '{8'hEE};
    send_stream();
    drain();

    // The receiver holds off while raw bytes keep coming, so the result queue fills up.
    configure(1'b0, 3'd1, 16'd64, 16'd1);
    rx_hold = 100;
    stream_image(64);
    drain();

    while (stim_bytes < RandomBytes) begin
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      sel = $urandom_range(0, 19);
      rle = 1'($urandom);
      bpp = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(1, 4)) : 3'($urandom_range(0, 7));
      budget = 100000;
      if (sel == 0) begin
        w = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom);
        h = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom);
        budget = 40;
      end else if (sel == 1) begin
        w = $urandom_range(0, 1) ? 16'd0 : 16'($urandom);
        h = (w == 16'd0) ? 16'($urandom) : 16'd0;
      end else begin
        w = 16'($urandom_range(1, 6));
        h = 16'($urandom_range(1, 6));
        if (sel == 2) budget = $urandom_range(1, 20);
      end
      configure(rle, bpp, w, h);
      stream_image(budget);
      repeat ($urandom_range(0, 2)) send_byte(8'($urandom));
      drain();
    end

    drain();
    if (pixel_pred.mismatches == 0 && pixel_pred.expected_pixels.size() == 0) begin
      $display("tga_rle_pixel_decoder_unit_tb: PASS");
    end else begin
      $display("tga_rle_pixel_decoder_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
